// ----- rtl/datetime_text_parser_top_defines.svh -----
// Assertion macros shared by the date-time parser RTL.
// Both macros sample on clk and are disabled while rst_n is low.
`ifndef DATETIME_TEXT_PARSER_TOP_DEFINES_SVH
`define DATETIME_TEXT_PARSER_TOP_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define DTP_ASSERT_SAME(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define DTP_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- rtl/dtp_pkg.sv -----
package dtp_pkg;

    localparam int YEAR_W   = 12;
    localparam int MONTH_W  = 4;
    localparam int DAY_W    = 5;
    localparam int HOUR_W   = 5;
    localparam int MINUTE_W = 6;
    localparam int SECOND_W = 6;
    localparam int MILLIS_W = 10;
    localparam int CHAR_W   = 8;
    localparam int ACC_W    = 13;
    localparam int STEP_W   = 3;
    localparam int BUDGET_W = 3;

    localparam logic [YEAR_W-1:0] MIN_YEAR_RESET = 12'd1583;

    // Field codes.
    localparam logic [STEP_W-1:0] STEP_YEAR   = 3'd0;
    localparam logic [STEP_W-1:0] STEP_MONTH  = 3'd1;
    localparam logic [STEP_W-1:0] STEP_DAY    = 3'd2;
    localparam logic [STEP_W-1:0] STEP_HOUR   = 3'd3;
    localparam logic [STEP_W-1:0] STEP_MINUTE = 3'd4;
    localparam logic [STEP_W-1:0] STEP_SECOND = 3'd5;
    localparam logic [STEP_W-1:0] STEP_MS     = 3'd6;

    // Character codes.
    localparam logic [CHAR_W-1:0] CHAR_NUL   = 8'h00;
    localparam logic [CHAR_W-1:0] CHAR_SPACE = 8'h20;
    localparam logic [CHAR_W-1:0] CHAR_DASH  = 8'h2D;
    localparam logic [CHAR_W-1:0] CHAR_DOT   = 8'h2E;
    localparam logic [CHAR_W-1:0] CHAR_ZERO  = 8'h30;
    localparam logic [CHAR_W-1:0] CHAR_NINE  = 8'h39;
    localparam logic [CHAR_W-1:0] CHAR_COLON = 8'h3A;
    localparam logic [CHAR_W-1:0] CHAR_T     = 8'h54;

    typedef struct packed {
        logic [STEP_W-1:0]   step;
        logic [ACC_W-1:0]    acc;
        logic [BUDGET_W-1:0] budget;
        logic                seen;
        logic [YEAR_W-1:0]   year;
        logic [MONTH_W-1:0]  month;
        logic [DAY_W-1:0]    day;
        logic [HOUR_W-1:0]   hour;
        logic [MINUTE_W-1:0] minute;
        logic [SECOND_W-1:0] second;
        logic [MILLIS_W-1:0] millis;
        logic                all_day;
        logic                all_sec;
        logic                done;
        logic                fail;
    } parse_state_t;

    typedef struct packed {
        logic                valid_res;
        logic [YEAR_W-1:0]   year;
        logic [MONTH_W-1:0]  month;
        logic [DAY_W-1:0]    day;
        logic [HOUR_W-1:0]   hour;
        logic [MINUTE_W-1:0] minute;
        logic [SECOND_W-1:0] second;
        logic [MILLIS_W-1:0] millis;
        logic                all_day;
        logic                all_sec;
    } result_t;

    function automatic logic [ACC_W-1:0] upper_limit(logic [STEP_W-1:0] s);
        logic [ACC_W-1:0] lim;
        unique case (s)
            STEP_YEAR:   lim = 13'd4095;
            STEP_MONTH:  lim = 13'd12;
            STEP_DAY:    lim = 13'd31;
            STEP_HOUR:   lim = 13'd23;
            STEP_MINUTE: lim = 13'd59;
            STEP_SECOND: lim = 13'd60;
            STEP_MS:     lim = 13'd999;
            default:     lim = '0;
        endcase
        return lim;
    endfunction

    function automatic logic [BUDGET_W-1:0] budget_init(logic [STEP_W-1:0] s);
        logic [BUDGET_W-1:0] b;
        unique case (s)
            STEP_YEAR: b = 3'd4;
            STEP_MS:   b = 3'd3;
            default:   b = 3'd2;
        endcase
        return b;
    endfunction

    function automatic parse_state_t start_field(parse_state_t st, logic [STEP_W-1:0] s);
        parse_state_t nx;
        nx        = st;
        nx.step   = s;
        nx.acc    = '0;
        nx.budget = budget_init(s);
        nx.seen   = 1'b0;
        return nx;
    endfunction

    function automatic parse_state_t parse_reset();
        parse_state_t nx;
        nx = '0;
        return start_field(nx, STEP_YEAR);
    endfunction

    // Consumes one character. A digit extends the current field when the
    // budget and the limit allow it; anything else closes the field and
    // is checked as its separator. A resolved parse is left unchanged.
    function automatic parse_state_t feed(parse_state_t st, logic [CHAR_W-1:0] c,
                                          logic [YEAR_W-1:0] min_year);
        parse_state_t            nx;
        logic [ACC_W+2:0]        acc_x10;
        logic [ACC_W-1:0]        lim;
        logic [ACC_W-1:0]        lo;
        logic [CHAR_W-1:0]       dig;
        logic                    is_digit;
        nx       = st;
        acc_x10  = ({3'b000, st.acc} << 3) + ({3'b000, st.acc} << 1);
        lim      = upper_limit(st.step);
        dig      = c - CHAR_ZERO;
        is_digit = (c >= CHAR_ZERO) && (c <= CHAR_NINE);
        lo       = (st.step == STEP_YEAR) ? {1'b0, min_year} : '0;
        if (st.done || st.fail) begin
            nx = st;
        end
        else if (st.step > STEP_MS) begin
            nx.fail    = 1'b1;
            nx.all_day = 1'b0;
            nx.all_sec = 1'b0;
        end
        else if (is_digit && (st.budget != '0) && (acc_x10 <= {3'b000, lim})) begin
            nx.acc    = acc_x10[ACC_W-1:0] + {{(ACC_W-4){1'b0}}, dig[3:0]};
            nx.budget = st.budget - 3'd1;
            nx.seen   = 1'b1;
        end
        else if (!st.seen || (st.acc < lo) || (st.acc > lim)) begin
            nx.fail    = 1'b1;
            nx.all_day = 1'b0;
            nx.all_sec = 1'b0;
        end
        else begin
            unique case (st.step)
                STEP_YEAR:
                begin
                    nx.year = st.acc[YEAR_W-1:0];
                    if (c == CHAR_DASH) nx = start_field(nx, STEP_MONTH);
                    else nx.fail = 1'b1;
                end
                STEP_MONTH:
                begin
                    nx.month = st.acc[MONTH_W-1:0];
                    if (c == CHAR_DASH) nx = start_field(nx, STEP_DAY);
                    else nx.fail = 1'b1;
                end
                STEP_DAY:
                begin
                    nx.day = st.acc[DAY_W-1:0];
                    if (c == CHAR_SPACE || c == CHAR_T) begin
                        nx = start_field(nx, STEP_HOUR);
                    end
                    else begin
                        nx.done    = 1'b1;
                        nx.all_day = 1'b1;
                    end
                end
                STEP_HOUR:
                begin
                    nx.hour = st.acc[HOUR_W-1:0];
                    if (c == CHAR_COLON) nx = start_field(nx, STEP_MINUTE);
                    else nx.fail = 1'b1;
                end
                STEP_MINUTE:
                begin
                    nx.minute = st.acc[MINUTE_W-1:0];
                    if (c == CHAR_COLON) nx = start_field(nx, STEP_SECOND);
                    else nx.fail = 1'b1;
                end
                STEP_SECOND:
                begin
                    nx.second = st.acc[SECOND_W-1:0];
                    if (c == CHAR_DOT) begin
                        nx = start_field(nx, STEP_MS);
                    end
                    else begin
                        nx.done    = 1'b1;
                        nx.all_sec = 1'b1;
                    end
                end
                default:
                begin
                    nx.millis = st.acc[MILLIS_W-1:0];
                    nx.done   = 1'b1;
                end
            endcase
        end
        return nx;
    endfunction

    // Builds the result item from a resolved parse.
    function automatic result_t make_result(parse_state_t st);
        result_t r;
        r = '0;
        if (st.done && !st.fail) begin
            r.valid_res = 1'b1;
            r.year      = st.year;
            r.month     = st.month;
            r.day       = st.day;
            if (st.all_day) begin
                r.all_day = 1'b1;
            end
            else begin
                r.hour    = st.hour;
                r.minute  = st.minute;
                r.second  = st.second;
                r.all_sec = st.all_sec;
                r.millis  = st.all_sec ? '0 : st.millis;
            end
        end
        return r;
    endfunction

endpackage

// ----- rtl/dtp_char_if.sv -----
interface dtp_char_if;
    logic                         valid;
    logic                         ready;
    logic [dtp_pkg::CHAR_W-1:0]   char_code;
    logic                         last;

    modport source (output valid, output char_code, output last, input ready);
    modport sink (input valid, input char_code, input last, output ready);
endinterface

// ----- rtl/dtp_result_if.sv -----
interface dtp_result_if;
    logic                           valid;
    logic                           ready;
    logic                           valid_res;
    logic [dtp_pkg::YEAR_W-1:0]     year;
    logic [dtp_pkg::MONTH_W-1:0]    month;
    logic [dtp_pkg::DAY_W-1:0]      day;
    logic [dtp_pkg::HOUR_W-1:0]     hour;
    logic [dtp_pkg::MINUTE_W-1:0]   minute;
    logic [dtp_pkg::SECOND_W-1:0]   second;
    logic [dtp_pkg::MILLIS_W-1:0]   millis;
    logic                           all_day;
    logic                           all_sec;

    modport source (output valid, output valid_res, output year, output month, output day,
                    output hour, output minute, output second, output millis,
                    output all_day, output all_sec, input ready);
    modport sink (input valid, input valid_res, input year, input month, input day,
                  input hour, input minute, input second, input millis,
                  input all_day, input all_sec, output ready);
endinterface

// ----- rtl/datetime_text_parser_top.sv -----
// A character is captured in the input stage and parsed from there into the parse state;
// when it is the last character of its string, the result register is loaded instead.
// Throughput: one character per cycle; a last character waits in the input stage only
// while the previous result is still held by a receiver that is not ready.
// Reset (rst_n low, asynchronous): parser back to the start of the year field, input
// and result stages empty, min_year back to 1583.
`include "datetime_text_parser_top_defines.svh"

module datetime_text_parser_top (
    input  logic                         clk,
    input  logic                         rst_n,
    dtp_char_if.sink                     char_in,
    dtp_result_if.source                 result_out,
    input  logic                         cfg_we,
    input  logic [dtp_pkg::YEAR_W-1:0]   cfg_wdata
);

    // The design is a two-register pipe. The input stage captures one
    // character per transfer. The parse state is updated from that stage
    // by a single combinational step: one multiply by ten with an add, one
    // limit compare and a separator check. On the character marked last, a
    // second closing step with an implicit NUL resolves any open field, the
    // result register is loaded and the parse state returns to its start
    // value.

    logic                          s1_valid_reg;
    logic [dtp_pkg::CHAR_W-1:0]    s1_char_reg;
    logic                          s1_last_reg;
    logic                          s1_adv;

    dtp_pkg::parse_state_t         st_reg;
    dtp_pkg::parse_state_t         st_next;
    dtp_pkg::parse_state_t         fed;
    dtp_pkg::parse_state_t         closed;

    logic                          out_valid_reg;
    logic                          out_valid_next;
    dtp_pkg::result_t              res_reg;

    logic [dtp_pkg::YEAR_W-1:0]    min_year_reg;

    // The input stage moves on unless it holds a last character whose
    // result has nowhere to go because the result register is still full.
    assign s1_adv        = s1_valid_reg &&
                           (!s1_last_reg || !out_valid_reg || result_out.ready);
    assign char_in.ready = !s1_valid_reg || s1_adv;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            s1_valid_reg <= 1'b0;
        end
        else if (char_in.ready) begin
            s1_valid_reg <= char_in.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (char_in.valid && char_in.ready) begin
            s1_char_reg <= char_in.char_code;
            s1_last_reg <= char_in.last;
        end
    end

    // The user must change configuration only between strings; the block does
    // not enforce this, and the register is read directly by the parse step.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            min_year_reg <= dtp_pkg::MIN_YEAR_RESET;
        end
        else if (cfg_we) begin
            min_year_reg <= cfg_wdata;
        end
    end

    // Parse step. The second feed does nothing once the parse is resolved.
    always_comb
    begin
        fed    = dtp_pkg::feed(st_reg, s1_char_reg, min_year_reg);
        closed = dtp_pkg::feed(fed, dtp_pkg::CHAR_NUL, min_year_reg);
        if (s1_adv) begin
            st_next = s1_last_reg ? dtp_pkg::parse_reset() : fed;
        end
        else begin
            st_next = st_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            st_reg <= dtp_pkg::parse_reset();
        end
        else begin
            st_reg <= st_next;
        end
    end

    // Result register. It is loaded only when empty or being emptied in
    // the same cycle, which the input-stage advance condition guarantees.
    always_comb
    begin
        if (s1_adv && s1_last_reg) begin
            out_valid_next = 1'b1;
        end
        else if (result_out.ready) begin
            out_valid_next = 1'b0;
        end
        else begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            out_valid_reg <= 1'b0;
        end
        else begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_adv && s1_last_reg) begin
            res_reg <= dtp_pkg::make_result(closed);
        end
    end

    assign result_out.valid     = out_valid_reg;
    assign result_out.valid_res = res_reg.valid_res;
    assign result_out.year      = res_reg.year;
    assign result_out.month     = res_reg.month;
    assign result_out.day       = res_reg.day;
    assign result_out.hour      = res_reg.hour;
    assign result_out.minute    = res_reg.minute;
    assign result_out.second    = res_reg.second;
    assign result_out.millis    = res_reg.millis;
    assign result_out.all_day   = res_reg.all_day;
    assign result_out.all_sec   = res_reg.all_sec;

    // A failed parse must present all fields as zero.
    `DTP_ASSERT_SAME(a_fail_zero, out_valid_reg && !res_reg.valid_res,
        res_reg.year == '0 && res_reg.month == '0 && res_reg.day == '0 &&
        res_reg.hour == '0 && res_reg.minute == '0 && res_reg.second == '0 &&
        res_reg.millis == '0 && !res_reg.all_day && !res_reg.all_sec,
        "failed result carries nonzero fields")
    // Date-only and no-fraction outcomes exclude each other.
    `DTP_ASSERT_SAME(a_flags_excl, out_valid_reg, !(res_reg.all_day && res_reg.all_sec),
        "result has both all_day and all_sec")
    // The parse can never be both finished and failed.
    `DTP_ASSERT_SAME(a_done_fail, 1'b1, !(st_reg.done && st_reg.fail),
        "parse state is done and failed at once")
    // Once a last character is processed the parser starts a fresh string.
    `DTP_ASSERT_NEXT(a_restart, s1_adv && s1_last_reg,
        st_reg.step == dtp_pkg::STEP_YEAR && !st_reg.done && !st_reg.fail &&
        !st_reg.seen && out_valid_reg,
        "parser did not restart after the last character")
    // Input backpressure only comes from a pending result.
    `DTP_ASSERT_SAME(a_stall_cause, !char_in.ready,
        s1_valid_reg && s1_last_reg && out_valid_reg && !result_out.ready,
        "input stalled without a pending result")

endmodule
